/* src/fspa_pkg.sv */
// Shared constants, codes and types of the fixed-slot pool allocator.
package fspa_pkg;

   localparam int MAX_SLOTS = 1024;
   localparam int ADDR_BITS = 48;

   // Fixed field widths.
   localparam int SIZE_BITS     = 17;
   localparam int ALIGN_BITS    = 13;
   localparam int CNT_REG_BITS  = 11;
   localparam int KIND_BITS     = 2;
   localparam int STATUS_BITS   = 3;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 5;
   localparam int REG_IDX_BITS  = 2;

   localparam int IDX_BITS   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int COUNT_BITS = $clog2(MAX_SLOTS + 1);
   localparam int PROD_BITS  = IDX_BITS + SIZE_BITS;

   // Pool span never exceeds 65536 * MAX_SLOTS bytes.
   localparam int OFF_BITS = SIZE_BITS - 1 + IDX_BITS;
   localparam int DIV_BITS = (ADDR_BITS < OFF_BITS) ? ADDR_BITS : OFF_BITS;
   localparam int CMP_BITS = (DIV_BITS > COUNT_BITS) ? DIV_BITS : COUNT_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

   localparam int SLOT_MIN = 8;
   localparam int SLOT_MAX = 65536;

   localparam int RST_SLOT_SIZE = 64;
   localparam int RST_ALIGN     = 8;
   localparam int RST_COUNT     = 1024;
   localparam int RST_EFF_COUNT = (RST_COUNT > MAX_SLOTS) ? MAX_SLOTS : RST_COUNT;

   localparam logic [KIND_BITS-1:0] KIND_ALLOC = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_FREE  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_QUERY = 2'd2;

   localparam logic [STATUS_BITS-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] STAT_EXHAUSTED = 3'd1;
   localparam logic [STATUS_BITS-1:0] STAT_BAD_REQ   = 3'd2;
   localparam logic [STATUS_BITS-1:0] STAT_NOT_OWNED = 3'd3;
   localparam logic [STATUS_BITS-1:0] STAT_NULL      = 3'd4;

   localparam logic [REG_IDX_BITS-1:0] REG_BASE  = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_SIZE  = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_ALIGN = 2'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_COUNT = 2'd3;

   // Effective pool geometry after clamping and padding.
   typedef struct packed {
      logic [ADDR_BITS-1:0]  base;
      logic [SIZE_BITS-1:0]  slot_bytes;
      logic [ALIGN_BITS-1:0] align;
      logic [COUNT_BITS-1:0] count;
   } cfg_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quo;
      logic                rem_zero;
   } div_res_type;

endpackage

/* src/fspa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fspa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/fspa_csr.sv */
// Configuration registers and effective pool geometry.
module fspa_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fspa_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [fspa_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [fspa_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready,
   output fspa_pkg::cfg_type                   cfg,
   output logic                                rebuild
);

   logic [fspa_pkg::ADDR_BITS-1:0]    base_ff, base_in;
   logic [fspa_pkg::SIZE_BITS-1:0]    size_ff, size_in;
   logic [fspa_pkg::ALIGN_BITS-1:0]   align_ff, align_in;
   logic [fspa_pkg::CNT_REG_BITS-1:0] count_ff, count_in;
   logic                              rebuild_ff, rebuild_in;

   logic                                wr_hit;
   logic [fspa_pkg::REG_IDX_BITS-1:0]   reg_idx;
   logic [fspa_pkg::ALIGN_BITS-1:0]     eff_align;
   logic [fspa_pkg::SIZE_BITS-1:0]      raw_clamped;
   logic [fspa_pkg::SIZE_BITS-1:0]      align_wide;
   logic [fspa_pkg::SIZE_BITS-1:0]      padded;
   logic [fspa_pkg::COUNT_BITS-1:0]     eff_count;

   assign pready  = 1'b1;
   assign wr_hit  = psel && penable && pwrite;
   assign reg_idx = paddr[fspa_pkg::CSR_ADDR_BITS-1:3];

   always_comb begin
      base_in    = base_ff;
      size_in    = size_ff;
      align_in   = align_ff;
      count_in   = count_ff;
      rebuild_in = 1'b0;
      if (wr_hit) begin
         rebuild_in = 1'b1;
         case (reg_idx)
            fspa_pkg::REG_BASE:  base_in  = pwdata[fspa_pkg::ADDR_BITS-1:0];
            fspa_pkg::REG_SIZE:  size_in  = pwdata[fspa_pkg::SIZE_BITS-1:0];
            fspa_pkg::REG_ALIGN: align_in = pwdata[fspa_pkg::ALIGN_BITS-1:0];
            fspa_pkg::REG_COUNT: count_in = pwdata[fspa_pkg::CNT_REG_BITS-1:0];
            default:             rebuild_in = 1'b0;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         fspa_pkg::REG_BASE:  prdata = fspa_pkg::CSR_DATA_BITS'(base_ff);
         fspa_pkg::REG_SIZE:  prdata = fspa_pkg::CSR_DATA_BITS'(size_ff);
         fspa_pkg::REG_ALIGN: prdata = fspa_pkg::CSR_DATA_BITS'(align_ff);
         fspa_pkg::REG_COUNT: prdata = fspa_pkg::CSR_DATA_BITS'(count_ff);
         default:             prdata = '0;
      endcase
   end

   // Alignment: highest set bit, zero counts as one.
   always_comb begin
      eff_align = fspa_pkg::ALIGN_BITS'(1);
      for (int i = 0; i < fspa_pkg::ALIGN_BITS; i++) begin
         if (align_ff[i]) begin
            eff_align = fspa_pkg::ALIGN_BITS'(1) << i;
         end
      end
   end

   always_comb begin
      if (size_ff < fspa_pkg::SIZE_BITS'(fspa_pkg::SLOT_MIN)) begin
         raw_clamped = fspa_pkg::SIZE_BITS'(fspa_pkg::SLOT_MIN);
      end else if (size_ff > fspa_pkg::SIZE_BITS'(fspa_pkg::SLOT_MAX)) begin
         raw_clamped = fspa_pkg::SIZE_BITS'(fspa_pkg::SLOT_MAX);
      end else begin
         raw_clamped = size_ff;
      end
      align_wide = fspa_pkg::SIZE_BITS'(eff_align);
      padded     = (raw_clamped + align_wide - fspa_pkg::SIZE_BITS'(1))
                   & ~(align_wide - fspa_pkg::SIZE_BITS'(1));
   end

   always_comb begin
      if (count_ff == '0) begin
         eff_count = fspa_pkg::COUNT_BITS'(1);
      end else if (32'(count_ff) > fspa_pkg::MAX_SLOTS) begin
         eff_count = fspa_pkg::COUNT_BITS'(fspa_pkg::MAX_SLOTS);
      end else begin
         eff_count = fspa_pkg::COUNT_BITS'(count_ff);
      end
   end

   assign cfg.base       = base_ff;
   assign cfg.slot_bytes = padded;
   assign cfg.align      = eff_align;
   assign cfg.count      = eff_count;
   assign rebuild        = rebuild_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         size_ff    <= fspa_pkg::SIZE_BITS'(fspa_pkg::RST_SLOT_SIZE);
         align_ff   <= fspa_pkg::ALIGN_BITS'(fspa_pkg::RST_ALIGN);
         count_ff   <= fspa_pkg::CNT_REG_BITS'(fspa_pkg::RST_COUNT);
         rebuild_ff <= 1'b0;
      end else begin
         base_ff    <= base_in;
         size_ff    <= size_in;
         align_ff   <= align_in;
         count_ff   <= count_in;
         rebuild_ff <= rebuild_in;
      end
   end

endmodule

/* src/fspa_divider.sv */
// Radix-2 restoring divider: slot offset over slot size, one quotient bit a cycle.
module fspa_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [fspa_pkg::DIV_BITS-1:0]  dividend,
   input  logic [fspa_pkg::SIZE_BITS-1:0] divisor,
   output fspa_pkg::div_res_type          result
);

   logic [fspa_pkg::SIZE_BITS-1:0]    rem_ff, rem_in;
   logic [fspa_pkg::DIV_BITS-1:0]     quo_ff, quo_in;
   logic [fspa_pkg::SIZE_BITS-1:0]    dvsr_ff, dvsr_in;
   logic [fspa_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;

   logic [fspa_pkg::SIZE_BITS:0] trial;
   logic [fspa_pkg::SIZE_BITS:0] diff;

   // Quotient register doubles as the dividend shifter.
   assign trial = {rem_ff, quo_ff[fspa_pkg::DIV_BITS-1]};
   assign diff  = trial - {1'b0, dvsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvsr_in = divisor;
         cnt_in  = fspa_pkg::DIV_CNT_BITS'(fspa_pkg::DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[fspa_pkg::SIZE_BITS]) begin
            rem_in = diff[fspa_pkg::SIZE_BITS-1:0];
            quo_in = {quo_ff[fspa_pkg::DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[fspa_pkg::SIZE_BITS-1:0];
            quo_in = {quo_ff[fspa_pkg::DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - fspa_pkg::DIV_CNT_BITS'(1);
         if (cnt_ff == fspa_pkg::DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign result.done     = done_ff;
   assign result.quo      = quo_ff;
   assign result.rem_zero = (rem_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

endmodule

/* src/fixed_slot_pool_allocator.sv */
// Fixed-slot pool allocator: LIFO free list in RAM, divider-based ownership test.
// Allocate: dispatch, pop, address, output; bad, exhausted, null, unknown, far address: dispatch, output.
// Query and unowned free: dispatch, divide, output; owned free: dispatch, divide, free, output.
// One item at a time; the next item is taken the cycle after its result is loaded into the
// output register, and a stall on rsp holds that load back.
// Sync reset; free list rebuilt at once after reset or a register write by a fresh watermark.
module fixed_slot_pool_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fspa_pkg::KIND_BITS-1:0]      req_kind,
   input  logic [fspa_pkg::ADDR_BITS-1:0]      req_address,
   input  logic [fspa_pkg::SIZE_BITS-1:0]      req_request_size,
   input  logic [fspa_pkg::ALIGN_BITS-1:0]     req_request_alignment,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fspa_pkg::ADDR_BITS-1:0]      rsp_result_address,
   output logic [fspa_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic                                rsp_owned,
   output logic [fspa_pkg::SIZE_BITS-1:0]      rsp_slot_bytes,
   output logic [fspa_pkg::CNT_REG_BITS-1:0]   rsp_slots_in_use,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fspa_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [fspa_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [fspa_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready
);

   localparam int IB = fspa_pkg::IDX_BITS;
   localparam int CB = fspa_pkg::COUNT_BITS;
   localparam int AB = fspa_pkg::ADDR_BITS;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_DISPATCH = 7'b0000010,
      ST_POP      = 7'b0000100,
      ST_ADDR     = 7'b0001000,
      ST_DIV      = 7'b0010000,
      ST_FREE     = 7'b0100000,
      ST_OUT      = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   fspa_pkg::cfg_type     cfg;
   fspa_pkg::div_res_type div_res;
   logic                  rebuild;

   logic [fspa_pkg::KIND_BITS-1:0]  kind_ff, kind_in;
   logic [AB-1:0]                   off_ff, off_in;
   logic                            null_ff, null_in;
   logic [fspa_pkg::SIZE_BITS-1:0]  rsize_ff, rsize_in;
   logic [fspa_pkg::ALIGN_BITS-1:0] ralign_ff, ralign_in;

   logic [IB-1:0] head_ff, head_in;
   logic [CB-1:0] fresh_ff, fresh_in;
   logic [CB-1:0] used_ff, used_in;
   logic [IB-1:0] idx_ff, idx_in;
   logic [fspa_pkg::PROD_BITS-1:0] prod_ff, prod_in;

   logic [AB-1:0]                    res_addr_ff, res_addr_in;
   logic [fspa_pkg::STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic                             res_own_ff, res_own_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [AB-1:0]                       rsp_addr_ff, rsp_addr_in;
   logic [fspa_pkg::STATUS_BITS-1:0]    rsp_status_ff, rsp_status_in;
   logic                                rsp_own_ff, rsp_own_in;
   logic [fspa_pkg::SIZE_BITS-1:0]      rsp_bytes_ff, rsp_bytes_in;
   logic [fspa_pkg::CNT_REG_BITS-1:0]   rsp_used_ff, rsp_used_in;

   logic          ram_wr_en;
   logic [IB-1:0] ram_wr_addr;
   logic [IB:0]   ram_wr_data;
   logic          ram_rd_en;
   logic [IB-1:0] ram_rd_addr;
   logic [IB:0]   ram_rd_data;

   logic div_start;
   logic off_high;
   logic req_bad;
   logic idx_fresh;
   logic div_owned;

   fspa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .rebuild (rebuild)
   );

   fspa_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (off_ff[fspa_pkg::DIV_BITS-1:0]),
      .divisor  (cfg.slot_bytes),
      .result   (div_res)
   );

   // Entry: {taken, next link}. Entries below the fresh watermark were never written.
   fspa_ram #(
      .WIDTH (IB + 1),
      .DEPTH (fspa_pkg::MAX_SLOTS)
   ) u_list (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign off_high  = ((off_ff >> fspa_pkg::DIV_BITS) != '0);
   assign req_bad   = (rsize_ff == '0) || (rsize_ff > cfg.slot_bytes)
                      || (ralign_ff == '0)
                      || ((ralign_ff & (ralign_ff - fspa_pkg::ALIGN_BITS'(1))) != '0)
                      || (ralign_ff > cfg.align);
   assign idx_fresh = (CB'(idx_ff) < fresh_ff);
   assign div_owned = div_res.rem_zero
                      && (fspa_pkg::CMP_BITS'(div_res.quo) < fspa_pkg::CMP_BITS'(cfg.count));

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      off_in        = off_ff;
      null_in       = null_ff;
      rsize_in      = rsize_ff;
      ralign_in     = ralign_ff;
      head_in       = head_ff;
      fresh_in      = fresh_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      prod_in       = prod_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      res_own_in    = res_own_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_own_in    = rsp_own_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_used_in   = rsp_used_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = head_ff;
      div_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               off_in    = req_address - cfg.base;
               null_in   = (req_address == '0);
               rsize_in  = req_request_size;
               ralign_in = req_request_alignment;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            res_addr_in   = '0;
            res_status_in = fspa_pkg::STAT_OK;
            res_own_in    = 1'b0;
            state_in      = ST_OUT;
            case (kind_ff)
               fspa_pkg::KIND_ALLOC: begin
                  if (req_bad) begin
                     res_status_in = fspa_pkg::STAT_BAD_REQ;
                  end else if (used_ff >= cfg.count) begin
                     res_status_in = fspa_pkg::STAT_EXHAUSTED;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = head_ff;
                     idx_in      = head_ff;
                     state_in    = ST_POP;
                  end
               end
               fspa_pkg::KIND_FREE: begin
                  if (null_ff) begin
                     res_status_in = fspa_pkg::STAT_NULL;
                  end else if (off_high) begin
                     res_status_in = fspa_pkg::STAT_NOT_OWNED;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
               fspa_pkg::KIND_QUERY: begin
                  if (!off_high) begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
               default: begin
                  res_status_in = fspa_pkg::STAT_BAD_REQ;
               end
            endcase
         end
         ST_POP: begin
            // Never-allocated slots chain downward implicitly.
            if (idx_fresh) begin
               head_in  = (idx_ff == '0) ? '0 : idx_ff - IB'(1);
               fresh_in = fresh_ff - CB'(1);
            end else begin
               head_in = ram_rd_data[IB-1:0];
            end
            used_in     = used_ff + CB'(1);
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = {1'b1, IB'(0)};
            prod_in     = fspa_pkg::PROD_BITS'(idx_ff) * fspa_pkg::PROD_BITS'(cfg.slot_bytes);
            state_in    = ST_ADDR;
         end
         ST_ADDR: begin
            res_addr_in = cfg.base + AB'(prod_ff);
            res_own_in  = 1'b1;
            state_in    = ST_OUT;
         end
         ST_DIV: begin
            if (div_res.done) begin
               idx_in = div_res.quo[IB-1:0];
               if (kind_ff == fspa_pkg::KIND_QUERY) begin
                  res_own_in = div_owned;
                  state_in   = ST_OUT;
               end else if (!div_owned) begin
                  res_status_in = fspa_pkg::STAT_NOT_OWNED;
                  state_in      = ST_OUT;
               end else begin
                  res_own_in  = 1'b1;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = div_res.quo[IB-1:0];
                  state_in    = ST_FREE;
               end
            end
         end
         ST_FREE: begin
            // Double free: slot is not taken.
            if (idx_fresh || !ram_rd_data[IB]) begin
               res_status_in = fspa_pkg::STAT_NOT_OWNED;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = idx_ff;
               ram_wr_data = {1'b0, head_ff};
               head_in     = idx_ff;
               used_in     = used_ff - CB'(1);
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               rsp_own_in    = res_own_ff;
               rsp_bytes_in  = res_own_ff ? cfg.slot_bytes : '0;
               rsp_used_in   = fspa_pkg::CNT_REG_BITS'(used_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rebuild) begin
         head_in  = IB'(cfg.count - CB'(1));
         fresh_in = cfg.count;
         used_in  = '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_owned          = rsp_own_ff;
   assign rsp_slot_bytes     = rsp_bytes_ff;
   assign rsp_slots_in_use   = rsp_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= IB'(fspa_pkg::RST_EFF_COUNT - 1);
         fresh_ff     <= CB'(fspa_pkg::RST_EFF_COUNT);
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fresh_ff     <= fresh_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      off_ff        <= off_in;
      null_ff       <= null_in;
      rsize_ff      <= rsize_in;
      ralign_ff     <= ralign_in;
      idx_ff        <= idx_in;
      prod_ff       <= prod_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      res_own_ff    <= res_own_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_own_ff    <= rsp_own_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_used_ff   <= rsp_used_in;
   end

endmodule

/* dv/fixed_slot_pool_allocator_checker.sv */
// Checker for the pool allocator: mirrors the free list, predicts each reply, compares beats.
`timescale 1ns / 1ps

module fixed_slot_pool_allocator_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [fspa_pkg::KIND_BITS-1:0]      req_kind,
   input  logic [fspa_pkg::ADDR_BITS-1:0]      req_address,
   input  logic [fspa_pkg::SIZE_BITS-1:0]      req_request_size,
   input  logic [fspa_pkg::ALIGN_BITS-1:0]     req_request_alignment,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [fspa_pkg::ADDR_BITS-1:0]      rsp_result_address,
   input  logic [fspa_pkg::STATUS_BITS-1:0]    rsp_status,
   input  logic                                rsp_owned,
   input  logic [fspa_pkg::SIZE_BITS-1:0]      rsp_slot_bytes,
   input  logic [fspa_pkg::CNT_REG_BITS-1:0]   rsp_slots_in_use,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fspa_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [fspa_pkg::CSR_DATA_BITS-1:0]  pwdata,
   input  logic                                pready,
   output int                                  fail_count,
   output int                                  pending_replies,
   output int                                  checked_beats
);
   import fspa_pkg::*;

   typedef struct packed {
      logic [ADDR_BITS-1:0]    addr;
      logic [STATUS_BITS-1:0]  status;
      logic                    owned;
      logic [SIZE_BITS-1:0]    slot_bytes;
      logic [CNT_REG_BITS-1:0] in_use;
   } pool_reply_type;

   pool_reply_type pool_replies_q[$];

   // register copies
   logic [ADDR_BITS-1:0]    cfg_base;
   logic [SIZE_BITS-1:0]    cfg_size;
   logic [ALIGN_BITS-1:0]   cfg_align;
   logic [CNT_REG_BITS-1:0] cfg_count;

   // effective geometry and free list mirror
   int geo_slot;
   int geo_align;
   int geo_count;
   int free_next[MAX_SLOTS];
   bit slot_busy[MAX_SLOTS];
   int free_top;
   int busy_slots;

   int miss_count = 0;
   int beat_count = 0;

   initial begin
      fail_count = 0;
      pending_replies = 0;
      checked_beats = 0;
   end

   function automatic void rebuild_pool();
      int p;
      int raw;
      int c;
      p = 1;
      for (int b = 0; b < ALIGN_BITS; b++)
         if (cfg_align[b]) p = 1 << b;
      raw = cfg_size;
      if (raw < SLOT_MIN) raw = SLOT_MIN;
      if (raw > SLOT_MAX) raw = SLOT_MAX;
      c = cfg_count;
      if (c == 0) c = 1;
      if (c > MAX_SLOTS) c = MAX_SLOTS;
      geo_align = p;
      geo_slot = (raw + p - 1) & ~(p - 1);
      geo_count = c;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         free_next[i] = (i == 0) ? 0 : i - 1;
         slot_busy[i] = 1'b0;
      end
      free_top = c - 1;
      busy_slots = 0;
   endfunction

   function automatic pool_reply_type predict_pool_op(logic [KIND_BITS-1:0] kind,
                                                      logic [ADDR_BITS-1:0] addr,
                                                      logic [SIZE_BITS-1:0] rsize,
                                                      logic [ALIGN_BITS-1:0] ralign);
      pool_reply_type r;
      logic [ADDR_BITS-1:0] off;
      logic [63:0] span;
      logic hit;
      int idx;
      r = '0;
      // offset wraps with the address space
      off = addr - cfg_base;
      span = 64'(geo_slot) * 64'(geo_count);
      hit = (64'(off) < span) && ((64'(off) % 64'(geo_slot)) == 0);
      idx = hit ? int'(64'(off) / 64'(geo_slot)) : 0;
      case (kind)
         KIND_ALLOC: begin
            if (rsize == 0 || rsize > geo_slot || ralign == 0 ||
                (ralign & (ralign - 1)) != 0 || ralign > geo_align) begin
               r.status = STAT_BAD_REQ;
            end else if (busy_slots >= geo_count) begin
               r.status = STAT_EXHAUSTED;
            end else begin
               idx = free_top;
               free_top = free_next[idx];
               slot_busy[idx] = 1'b1;
               busy_slots++;
               r.addr = cfg_base + 48'(idx) * 48'(geo_slot);
               r.owned = 1'b1;
            end
         end
         KIND_FREE: begin
            if (addr == 0) begin
               r.status = STAT_NULL;
            end else if (!hit) begin
               r.status = STAT_NOT_OWNED;
            end else begin
               r.owned = 1'b1;
               if (!slot_busy[idx]) begin
                  r.status = STAT_NOT_OWNED;   // slot already on the free list
               end else begin
                  free_next[idx] = free_top;
                  free_top = idx;
                  slot_busy[idx] = 1'b0;
                  busy_slots--;
               end
            end
         end
         KIND_QUERY: begin
            r.owned = hit;
         end
         default: begin
            r.status = STAT_BAD_REQ;
         end
      endcase
      r.slot_bytes = r.owned ? SIZE_BITS'(geo_slot) : '0;
      r.in_use = CNT_REG_BITS'(busy_slots);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      miss_count++;
      $display("%0t ns MISMATCH beat %0d: %s got %h want %h", $time, beat_count, what,
               got, want);
   endtask

   always @(posedge clock) begin
      pool_reply_type want;
      if (reset) begin
         cfg_base = '0;
         cfg_size = SIZE_BITS'(RST_SLOT_SIZE);
         cfg_align = ALIGN_BITS'(RST_ALIGN);
         cfg_count = CNT_REG_BITS'(RST_COUNT);
         rebuild_pool();
         pool_replies_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pool_replies_q.size() == 0) begin
               report_mismatch("beat with no reply expected, status", 64'(rsp_status), 64'd0);
            end else begin
               want = pool_replies_q.pop_front();
               if (rsp_result_address !== want.addr)
                  report_mismatch("result_address", 64'(rsp_result_address), 64'(want.addr));
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_owned !== want.owned)
                  report_mismatch("owned", 64'(rsp_owned), 64'(want.owned));
               if (rsp_slot_bytes !== want.slot_bytes)
                  report_mismatch("slot_bytes", 64'(rsp_slot_bytes), 64'(want.slot_bytes));
               if (rsp_slots_in_use !== want.in_use)
                  report_mismatch("slots_in_use", 64'(rsp_slots_in_use), 64'(want.in_use));
            end
            beat_count++;
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:3])
               REG_BASE:  cfg_base = pwdata[ADDR_BITS-1:0];
               REG_SIZE:  cfg_size = pwdata[SIZE_BITS-1:0];
               REG_ALIGN: cfg_align = pwdata[ALIGN_BITS-1:0];
               REG_COUNT: cfg_count = pwdata[CNT_REG_BITS-1:0];
               default: ;
            endcase
            rebuild_pool();
         end
         if (req_valid && !req_stall)
            pool_replies_q.push_back(predict_pool_op(req_kind, req_address,
                                                     req_request_size,
                                                     req_request_alignment));
      end
      pending_replies <= pool_replies_q.size();
      fail_count <= miss_count;
      checked_beats <= beat_count;
   end

endmodule

/* dv/fixed_slot_pool_allocator_tb.sv */
// Testbench top for the pool allocator: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module fixed_slot_pool_allocator_tb;
   import fspa_pkg::*;

   localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 2'd3;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [KIND_BITS-1:0]     req_kind = '0;
   logic [ADDR_BITS-1:0]     req_address = '0;
   logic [SIZE_BITS-1:0]     req_request_size = '0;
   logic [ALIGN_BITS-1:0]    req_request_alignment = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [ADDR_BITS-1:0]     rsp_result_address;
   logic [STATUS_BITS-1:0]   rsp_status;
   logic                     rsp_owned;
   logic [SIZE_BITS-1:0]     rsp_slot_bytes;
   logic [CNT_REG_BITS-1:0]  rsp_slots_in_use;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   int fail_count;
   int pending_replies;
   int checked_beats;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int sent_count = 0;

   // geometry the stimulus aims at
   logic [ADDR_BITS-1:0] cur_base = '0;
   int cur_slot = 64;
   int cur_align_log = 3;
   int cur_count = 1024;

   fixed_slot_pool_allocator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_address(req_address), .req_request_size(req_request_size),
      .req_request_alignment(req_request_alignment),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_address(rsp_result_address), .rsp_status(rsp_status),
      .rsp_owned(rsp_owned), .rsp_slot_bytes(rsp_slot_bytes),
      .rsp_slots_in_use(rsp_slots_in_use),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   fixed_slot_pool_allocator_checker pool_watch (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_address(req_address), .req_request_size(req_request_size),
      .req_request_alignment(req_request_alignment),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_address(rsp_result_address), .rsp_status(rsp_status),
      .rsp_owned(rsp_owned), .rsp_slot_bytes(rsp_slot_bytes),
      .rsp_slots_in_use(rsp_slots_in_use),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .pending_replies(pending_replies),
      .checked_beats(checked_beats)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Timeout with %0d replies outstanding", pending_replies);
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock)
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

   // valid stays up across back-to-back beats; only an idle cycle or wait_idle lowers it
   task automatic push_req(input logic [KIND_BITS-1:0] kind, input logic [ADDR_BITS-1:0] addr,
                           input logic [SIZE_BITS-1:0] rsize,
                           input logic [ALIGN_BITS-1:0] ralign);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_address <= addr;
      req_request_size <= rsize;
      req_request_alignment <= ralign;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_replies != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_geometry(input logic [ADDR_BITS-1:0] base,
                                 input logic [SIZE_BITS-1:0] raw,
                                 input logic [ALIGN_BITS-1:0] align_reg,
                                 input logic [CNT_REG_BITS-1:0] count_reg,
                                 input int slot, input int align_log, input int n);
      wait_idle();
      csr_write(REG_BASE, CSR_DATA_BITS'(base));
      csr_write(REG_SIZE, CSR_DATA_BITS'(raw));
      csr_write(REG_ALIGN, CSR_DATA_BITS'(align_reg));
      csr_write(REG_COUNT, CSR_DATA_BITS'(count_reg));
      cur_base = base;
      cur_slot = slot;
      cur_align_log = align_log;
      cur_count = n;
   endtask

   task automatic random_request();
      logic [KIND_BITS-1:0]  kind;
      logic [ADDR_BITS-1:0]  addr;
      logic [SIZE_BITS-1:0]  rsize;
      logic [ALIGN_BITS-1:0] ralign;
      int pick;
      int idx;
      int reach;
      pick = $urandom_range(99);
      addr = ADDR_BITS'({$urandom, $urandom});
      rsize = SIZE_BITS'($urandom_range(1, cur_slot));
      ralign = ALIGN_BITS'(1) << $urandom_range(0, cur_align_log);
      // recently handed out slots sit near the top of the index range
      reach = (cur_count > 64) ? 63 : cur_count - 1;
      idx = cur_count - 1 - $urandom_range(0, reach);
      if (pick < 45) begin
         kind = KIND_ALLOC;
         case ($urandom_range(19))
            0: rsize = '0;
            1: rsize = SIZE_BITS'($urandom_range(cur_slot + 1, 131071));
            2: ralign = '0;
            3: ralign = ALIGN_BITS'(3) << $urandom_range(0, 10);
            4: ralign = (cur_align_log == 12) ? 13'h1FFF : ALIGN_BITS'(2) << cur_align_log;
            default: ;
         endcase
      end else if (pick < 95) begin
         kind = (pick < 85) ? KIND_FREE : KIND_QUERY;
         case ($urandom_range(9))
            0: addr = cur_base + 48'(idx) * 48'(cur_slot) + 48'($urandom_range(1, cur_slot - 1));
            1: addr = cur_base + 48'(cur_count) * 48'(cur_slot);
            2: ;
            3: if (kind == KIND_FREE) addr = '0;
            default: addr = cur_base + 48'(idx) * 48'(cur_slot);
         endcase
      end else begin
         kind = KIND_BITS'($urandom_range(0, 3));
         rsize = SIZE_BITS'($urandom);
         ralign = ALIGN_BITS'($urandom);
      end
      push_req(kind, addr, rsize, ralign);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: 64-byte slots, align 8, 1024 slots at address zero
      push_req(KIND_ALLOC, 48'h0, 17'd1, 13'd1);
      push_req(KIND_ALLOC, 48'hFFFF_FFFF_FFFF, 17'd64, 13'd8);
      push_req(KIND_ALLOC, 48'h0, 17'd65, 13'd8);
      push_req(KIND_ALLOC, 48'h0, 17'd0, 13'd1);
      push_req(KIND_ALLOC, 48'h0, 17'd8, 13'd16);
      push_req(KIND_ALLOC, 48'h0, 17'd8, 13'd3);
      push_req(KIND_ALLOC, 48'h0, 17'h1FFFF, 13'h1FFF);
      push_req(KIND_ALLOC, 48'h0, 17'h10000, 13'h1000);
      push_req(KIND_UNKNOWN, 48'hFFFF_FFFF_FFFF, 17'h1FFFF, 13'h1FFF);
      push_req(KIND_FREE, 48'h0, 17'd0, 13'd0);
      push_req(KIND_FREE, 48'hFFC1, 17'd0, 13'd0);
      push_req(KIND_FREE, 48'h1_0000, 17'd0, 13'd0);
      push_req(KIND_QUERY, 48'h0, 17'd0, 13'd0);
      push_req(KIND_QUERY, 48'hFFFF_FFFF_FFFF, 17'd0, 13'd0);
      push_req(KIND_FREE, 48'hFFC0, 17'd0, 13'd0);
      push_req(KIND_FREE, 48'hFFC0, 17'd0, 13'd0);
      push_req(KIND_QUERY, 48'hFF80, 17'd0, 13'd0);
      push_req(KIND_ALLOC, 48'h0, 17'd64, 13'd8);

      // tiny pool straddling the top of the address space: slot 2 sits at address zero
      apply_geometry(48'hFFFF_FFFF_FFF0, 17'd5, 13'd0, 11'd4, 8, 0, 4);
      repeat (4) push_req(KIND_ALLOC, 48'h0, 17'd8, 13'd1);
      push_req(KIND_ALLOC, 48'h0, 17'd8, 13'd1);
      push_req(KIND_ALLOC, 48'h0, 17'd9, 13'd1);
      push_req(KIND_FREE, 48'h0, 17'd0, 13'd0);
      push_req(KIND_FREE, 48'h8, 17'd0, 13'd0);
      push_req(KIND_QUERY, 48'h0, 17'd0, 13'd0);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 49; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 49; end
            default: begin send_idle_pct = 20; stall_pct = 20; end
         endcase
         for (int k = 0; k < 2; k++) begin
            case (ph * 2 + k)
               0: apply_geometry(48'h0000_1000_0000, 17'd64, 13'd8, 11'd16, 64, 3, 16);
               1: apply_geometry(48'hFFFF_FFFF_FF00, 17'd100, 13'd32, 11'd8, 128, 5, 8);
               2: apply_geometry(48'h1234_5678_9A00, 17'h1FFFF, 13'h1FFF, 11'h7FF,
                                 65536, 12, 1024);
               3: apply_geometry(48'hFFFF_FFFF_FFFF, 17'd0, 13'd0, 11'd0, 8, 0, 1);
               4: apply_geometry(48'h0000_0000_0040, 17'd24, 13'd1, 11'd1024, 24, 0, 1024);
               5: apply_geometry(48'h8000_0000_0000, 17'd65536, 13'd4096, 11'd5, 65536, 12, 5);
               6: apply_geometry(48'h0000_0000_0ABC, 17'd9, 13'd2, 11'd32, 10, 1, 32);
               default: apply_geometry(48'h7FFF_FFFF_0000, 17'd4095, 13'd4096, 11'd3,
                                       4096, 12, 3);
            endcase
            repeat (172) begin
               random_request();
               if ($urandom_range(199) == 0) wait_idle();
            end
         end
      end

      wait_idle();
      repeat (40) @(posedge clock);
      $display("Summary: %0d requests sent, %0d reply beats checked", sent_count,
               checked_beats);
      $display("Summary: ten pool geometries incl. clamped, wrapping and exhausted pools, "
               , "four flow-control mixes");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
src/fspa_pkg.sv
src/fspa_ram.sv
src/fspa_csr.sv
src/fspa_divider.sv
src/fixed_slot_pool_allocator.sv
dv/fixed_slot_pool_allocator_checker.sv
dv/fixed_slot_pool_allocator_tb.sv
